// ----- hdl/i2c_master_byte_engine_unit_defines.svh -----
// Assertion helpers for the I2C master byte engine.
// Both sample on the rising edge of clk and stay quiet while arst_n is low.
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define I2CMBE_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication.
`define I2CMBE_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- hdl/i2cmbe_pkg.sv -----
`default_nettype none

package i2cmbe_pkg;

	localparam int HalfW = 16;
	localparam int ByteW = 8;
	localparam int BitIdxW = 4;
	localparam int ActionW = 3;
	localparam logic [BitIdxW-1:0] AckBit = BitIdxW'(ByteW);
	localparam logic [HalfW-1:0] HalfPeriodReset = 16'd4;
	localparam logic [HalfW-1:0] TickFirst = 16'd1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START_HI,
		PH_START_LO,
		PH_STOP_PRE,
		PH_STOP_HI,
		PH_STOP_REL,
		PH_BIT_LOW,
		PH_BIT_HIGH
	} phase_t;

	localparam logic [ActionW-1:0] ACT_TICK  = 3'd0;
	localparam logic [ActionW-1:0] ACT_START = 3'd1;
	localparam logic [ActionW-1:0] ACT_STOP  = 3'd2;
	localparam logic [ActionW-1:0] ACT_WRITE = 3'd3;
	localparam logic [ActionW-1:0] ACT_READ  = 3'd4;

	typedef struct packed {
		phase_t              phase;
		logic [BitIdxW-1:0]  bit_index;
		logic [ByteW-1:0]    shifter;
		logic [HalfW-1:0]    tick_count;
		logic                is_write;
		logic                ack_request;
		logic                scl_level;
		logic                sda_low;
		logic                ack_seen;
		logic [ByteW-1:0]    last_read;
	} state_t;

	typedef struct packed {
		logic             scl;
		logic             sda_pull_low;
		logic             busy_res;
		logic             done_res;
		logic [ByteW-1:0] read_byte;
		logic             ack_received;
	} result_t;

endpackage

`default_nettype wire

// ----- hdl/i2cmbe_if.sv -----
`default_nettype none

interface i2cmbe_req_if import i2cmbe_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ActionW-1:0] action;
	logic [ByteW-1:0]   write_byte;
	logic               send_ack;
	logic               sda_in;

	modport source (output valid, action, write_byte, send_ack, sda_in, input ready);
	modport sink (input valid, action, write_byte, send_ack, sda_in, output ready);
endinterface

interface i2cmbe_rsp_if import i2cmbe_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             scl;
	logic             sda_pull_low;
	logic             busy_res;
	logic             done_res;
	logic [ByteW-1:0] read_byte;
	logic             ack_received;

	modport source (output valid, scl, sda_pull_low, busy_res, done_res, read_byte,
		ack_received, input ready);
	modport sink (input valid, scl, sda_pull_low, busy_res, done_res, read_byte,
		ack_received, output ready);
endinterface

`default_nettype wire

// ----- hdl/i2cmbe_step.sv -----
`default_nettype none

module i2cmbe_step
	import i2cmbe_pkg::*;
(
	input  state_t             cur,
	input  logic [HalfW-1:0]   half_period,
	input  logic [ActionW-1:0] action,
	input  logic [ByteW-1:0]   write_byte,
	input  logic               send_ack,
	input  logic               sda_in,
	output state_t             nxt,
	output logic               done
);

	logic [ByteW-1:0]   shifted;
	logic [BitIdxW-1:0] next_bit;
	logic               next_pull;

	always_comb begin
		shifted = cur.is_write ? {cur.shifter[ByteW-2:0], 1'b0}
			: {cur.shifter[ByteW-2:0], sda_in};
		next_bit = cur.bit_index + BitIdxW'(1);
		if (next_bit < AckBit) begin
			next_pull = cur.is_write ? ~shifted[ByteW-1] : 1'b0;
		end else begin
			next_pull = cur.is_write ? 1'b0 : cur.ack_request;
		end
	end

	always_comb begin
		nxt = cur;
		done = 1'b0;
		case (cur.phase)
			PH_IDLE: begin
				case (action)
					ACT_START: begin
						nxt.is_write = 1'b0;
						nxt.phase = PH_START_HI;
						nxt.scl_level = 1'b1;
						nxt.sda_low = 1'b0;
						nxt.tick_count = TickFirst;
					end
					ACT_STOP: begin
						nxt.is_write = 1'b0;
						nxt.phase = PH_STOP_PRE;
						nxt.scl_level = 1'b0;
						nxt.sda_low = 1'b1;
						nxt.tick_count = TickFirst;
					end
					ACT_WRITE: begin
						nxt.is_write = 1'b1;
						nxt.bit_index = '0;
						nxt.shifter = write_byte;
						nxt.phase = PH_BIT_LOW;
						nxt.scl_level = 1'b0;
						nxt.sda_low = ~write_byte[ByteW-1];
						nxt.tick_count = TickFirst;
					end
					ACT_READ: begin
						nxt.is_write = 1'b0;
						nxt.bit_index = '0;
						nxt.shifter = '0;
						nxt.ack_request = send_ack;
						nxt.phase = PH_BIT_LOW;
						nxt.scl_level = 1'b0;
						nxt.sda_low = 1'b0;
						nxt.tick_count = TickFirst;
					end
					default: begin
					end
				endcase
			end
			default: begin
				if (cur.tick_count < half_period) begin
					nxt.tick_count = cur.tick_count + HalfW'(1);
				end else begin
					case (cur.phase)
						PH_START_HI: begin
							nxt.phase = PH_START_LO;
							nxt.scl_level = 1'b1;
							nxt.sda_low = 1'b1;
							nxt.tick_count = TickFirst;
						end
						PH_STOP_PRE: begin
							nxt.phase = PH_STOP_HI;
							nxt.scl_level = 1'b1;
							nxt.sda_low = 1'b1;
							nxt.tick_count = TickFirst;
						end
						PH_STOP_HI: begin
							nxt.phase = PH_STOP_REL;
							nxt.scl_level = 1'b1;
							nxt.sda_low = 1'b0;
							nxt.tick_count = TickFirst;
						end
						PH_BIT_LOW: begin
							nxt.phase = PH_BIT_HIGH;
							nxt.scl_level = 1'b1;
							nxt.tick_count = TickFirst;
						end
						PH_BIT_HIGH: begin
							if (cur.bit_index < AckBit) begin
								nxt.shifter = shifted;
								nxt.bit_index = next_bit;
								nxt.phase = PH_BIT_LOW;
								nxt.scl_level = 1'b0;
								nxt.sda_low = next_pull;
								nxt.tick_count = TickFirst;
							end else begin
								if (cur.is_write) begin
									nxt.ack_seen = ~sda_in;
								end else begin
									nxt.last_read = cur.shifter;
								end
								nxt.scl_level = 1'b0;
								nxt.phase = PH_IDLE;
								done = 1'b1;
							end
						end
						default: begin
							nxt.phase = PH_IDLE;
							done = 1'b1;
						end
					endcase
				end
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hdl/i2cmbe_out_reg.sv -----
`default_nettype none

module i2cmbe_out_reg
	import i2cmbe_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t data,
	output logic    space,
	i2cmbe_rsp_if.source rsp
);

	logic    valid_q;
	result_t data_q;

	assign space = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data;
		end
	end

	assign rsp.valid = valid_q;
	assign rsp.scl = data_q.scl;
	assign rsp.sda_pull_low = data_q.sda_pull_low;
	assign rsp.busy_res = data_q.busy_res;
	assign rsp.done_res = data_q.done_res;
	assign rsp.read_byte = data_q.read_byte;
	assign rsp.ack_received = data_q.ack_received;

endmodule

`default_nettype wire

// ----- hdl/i2c_master_byte_engine_unit.sv -----
// I2C master byte engine: one bus timing tick per request.
// req carries action, write_byte, send_ack and the sampled sda_in. While the
// engine is idle, action 1..4 starts a start, stop, byte write or byte read;
// otherwise the request only advances time. Each phase lasts half_period
// requests (at least one); the user must write it through cfg_we/cfg_data
// only while the engine is idle (not enforced). rsp returns one result per
// request: the scl level, the SDA pull-down, busy/done flags, the last read
// byte and the last write acknowledge. A request's result is valid on rsp
// the cycle after it is taken. Throughput: one request per cycle; the state
// update is a single pass of next-state logic into the state register and
// the result register. A stalled rsp holds its result and drops req.ready
// until it is taken; while rsp.ready is high a new request is taken every
// cycle. Reset: bus released (scl high, SDA not pulled), engine idle, flags
// and read byte cleared, half_period back to 4, no result pending.
`default_nettype none
`include "i2c_master_byte_engine_unit_defines.svh"

module i2c_master_byte_engine_unit
	import i2cmbe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [HalfW-1:0] cfg_data,
	i2cmbe_req_if.sink       req,
	i2cmbe_rsp_if.source     rsp
);

	logic [HalfW-1:0] half_period_q;
	state_t           state_q;
	state_t           state_nxt;
	logic             step_done;
	logic             space;
	logic             req_fire;
	result_t          result;

	assign req.ready = space;
	assign req_fire = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HalfPeriodReset;
		end else if (cfg_we) begin
			half_period_q <= cfg_data;
		end
	end

	i2cmbe_step u_step (
		.cur         (state_q),
		.half_period (half_period_q),
		.action      (req.action),
		.write_byte  (req.write_byte),
		.send_ack    (req.send_ack),
		.sda_in      (req.sda_in),
		.nxt         (state_nxt),
		.done        (step_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= PH_IDLE;
			state_q.bit_index <= '0;
			state_q.shifter <= '0;
			state_q.tick_count <= '0;
			state_q.is_write <= 1'b0;
			state_q.ack_request <= 1'b0;
			state_q.scl_level <= 1'b1;
			state_q.sda_low <= 1'b0;
			state_q.ack_seen <= 1'b0;
			state_q.last_read <= '0;
		end else if (req_fire) begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		result.scl = state_nxt.scl_level;
		result.sda_pull_low = state_nxt.sda_low;
		result.busy_res = (state_nxt.phase != PH_IDLE);
		result.done_res = step_done;
		result.read_byte = state_nxt.last_read;
		result.ack_received = state_nxt.ack_seen;
	end

	i2cmbe_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (req_fire),
		.data   (result),
		.space  (space),
		.rsp    (rsp)
	);

	`I2CMBE_ASSERT_NOW(a_done_not_busy, rsp.valid && rsp.done_res, !rsp.busy_res, "done while busy")
	`I2CMBE_ASSERT_NOW(a_stall_blocks, rsp.valid && !rsp.ready, !req.ready, "request taken over stalled result")
	`I2CMBE_ASSERT_NEXT(a_phase_hold, req_fire && state_q.phase != PH_IDLE && state_q.tick_count < half_period_q, $stable(state_q.phase), "phase left early")
	`I2CMBE_ASSERT_NOW(a_bit_range, state_q.phase == PH_BIT_LOW || state_q.phase == PH_BIT_HIGH, state_q.bit_index <= AckBit, "bit index past acknowledge")

endmodule

`default_nettype wire

// ----- dv/i2cmbe_checker.sv -----
`timescale 1ns / 100ps

module i2cmbe_checker
	import i2cmbe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [HalfW-1:0] cfg_data,
	i2cmbe_req_if            req,
	i2cmbe_rsp_if            rsp,
	output int               mismatches,
	output int               outstanding,
	output logic             engine_busy
);

	logic [HalfW-1:0]   half_period;
	phase_t             ph;
	logic [BitIdxW-1:0] bit_pos;
	logic [ByteW-1:0]   shift_reg;
	logic [HalfW-1:0]   tick_cnt;
	logic [ActionW-1:0] cmd;
	logic               ack_req;
	logic               scl_lvl;
	logic               sda_pull;
	logic               ack_seen;
	logic [ByteW-1:0]   last_read;

	result_t expected_bus_q[$];
	int      errs;

	function automatic void go_phase(input phase_t nxt, input logic scl, input logic pull);
		ph = nxt;
		scl_lvl = scl;
		sda_pull = pull;
		tick_cnt = TickFirst;
	endfunction

	// data bits: write drives the inverted MSB; ninth bit: write releases, read sends ACK/NACK
	function automatic logic bit_pull();
		if (bit_pos < AckBit)
			return (cmd == ACT_WRITE) ? ~shift_reg[ByteW-1] : 1'b0;
		return (cmd == ACT_WRITE) ? 1'b0 : ack_req;
	endfunction

	function automatic result_t bus_tick(input logic [ActionW-1:0] act,
			input logic [ByteW-1:0] wb, input logic sa, input logic sd);
		result_t r;
		logic    done;
		done = 1'b0;
		if (ph == PH_IDLE) begin
			if (act >= ACT_START && act <= ACT_READ) begin
				cmd = act;
				if (act == ACT_START) begin
					go_phase(PH_START_HI, 1'b1, 1'b0);
				end else if (act == ACT_STOP) begin
					go_phase(PH_STOP_PRE, 1'b0, 1'b1);
				end else begin
					bit_pos = '0;
					shift_reg = (act == ACT_WRITE) ? wb : '0;
					if (act == ACT_READ)
						ack_req = sa;
					go_phase(PH_BIT_LOW, 1'b0, bit_pull());
				end
			end
		end else if (tick_cnt >= half_period) begin
			case (ph)
				PH_START_HI: go_phase(PH_START_LO, 1'b1, 1'b1);
				PH_STOP_PRE: go_phase(PH_STOP_HI, 1'b1, 1'b1);
				PH_STOP_HI:  go_phase(PH_STOP_REL, 1'b1, 1'b0);
				PH_BIT_LOW:  go_phase(PH_BIT_HIGH, 1'b1, sda_pull);
				PH_START_LO, PH_STOP_REL: begin
					ph = PH_IDLE;
					done = 1'b1;
				end
				PH_BIT_HIGH: begin
					if (bit_pos < AckBit) begin
						shift_reg = {shift_reg[ByteW-2:0], (cmd == ACT_WRITE) ? 1'b0 : sd};
						bit_pos = bit_pos + 1'b1;
						go_phase(PH_BIT_LOW, 1'b0, bit_pull());
					end else begin
						if (cmd == ACT_WRITE)
							ack_seen = ~sd;
						else
							last_read = shift_reg;
						scl_lvl = 1'b0;
						ph = PH_IDLE;
						done = 1'b1;
					end
				end
				default: ph = PH_IDLE;
			endcase
		end else begin
			tick_cnt = tick_cnt + 1'b1;
		end
		r.scl = scl_lvl;
		r.sda_pull_low = sda_pull;
		r.busy_res = (ph != PH_IDLE);
		r.done_res = done;
		r.read_byte = last_read;
		r.ack_received = ack_seen;
		return r;
	endfunction

	task automatic cmp_field(input string name, input logic [ByteW-1:0] want,
			input logic [ByteW-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			half_period = HalfPeriodReset;
			ph = PH_IDLE;
			bit_pos = '0;
			shift_reg = '0;
			tick_cnt = '0;
			cmd = ACT_TICK;
			ack_req = 1'b0;
			scl_lvl = 1'b1;
			sda_pull = 1'b0;
			ack_seen = 1'b0;
			last_read = '0;
			expected_bus_q.delete();
			errs = 0;
		end else begin
			if (cfg_we)
				half_period = cfg_data;
			if (rsp.valid && rsp.ready) begin
				if (expected_bus_q.size() == 0) begin
					$display("%0t: result with nothing expected, scl %0b sda_pull_low %0b",
						$time, rsp.scl, rsp.sda_pull_low);
					errs++;
				end else begin
					want = expected_bus_q.pop_front();
					cmp_field("scl", want.scl, rsp.scl);
					cmp_field("sda_pull_low", want.sda_pull_low, rsp.sda_pull_low);
					cmp_field("busy_res", want.busy_res, rsp.busy_res);
					cmp_field("done_res", want.done_res, rsp.done_res);
					cmp_field("read_byte", want.read_byte, rsp.read_byte);
					cmp_field("ack_received", want.ack_received, rsp.ack_received);
				end
			end
			if (req.valid && req.ready)
				expected_bus_q.push_back(bus_tick(req.action, req.write_byte, req.send_ack,
					req.sda_in));
		end
		mismatches <= errs;
		outstanding <= expected_bus_q.size();
		engine_busy <= (ph != PH_IDLE);
	end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import i2cmbe_pkg::*;

	localparam longint LimitNs = 64'd3_000_000 * 12;
	localparam int LongHold = 300;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we;
	logic [HalfW-1:0] cfg_data;
	int               mismatches;
	int               outstanding;
	logic             engine_busy;
	int               hold_token;
	int               sender_gap_pct;

	i2cmbe_req_if req_if ();
	i2cmbe_rsp_if rsp_if ();

	i2c_master_byte_engine_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.req      (req_if),
		.rsp      (rsp_if)
	);

	i2cmbe_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.req         (req_if),
		.rsp         (rsp_if),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.engine_busy (engine_busy)
	);

	always #6 clk = ~clk;

	initial begin
		#(LimitNs);
		$display("i2c_master_byte_engine_unit verification failed");
		$finish;
	end

	initial begin
		int   hold_seen;
		int   epoch_left;
		logic calm;
		hold_seen = 0;
		epoch_left = 0;
		calm = 1'b0;
		rsp_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				rsp_if.ready <= 1'b0;
				repeat (LongHold) @(posedge clk);
			end else begin
				if (epoch_left == 0) begin
					calm = ($urandom_range(2, 0) == 0);
					epoch_left = calm ? 400 : 300;
				end
				epoch_left--;
				rsp_if.ready <= calm || ($urandom_range(99, 0) >= 25);
			end
		end
	end

	task automatic send_req(input logic [ActionW-1:0] act, input logic [ByteW-1:0] wb,
			input logic sa, input logic sd);
		if (sender_gap_pct != 0 && $urandom_range(99, 0) < sender_gap_pct) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.action <= act;
		req_if.write_byte <= wb;
		req_if.send_ack <= sa;
		req_if.sda_in <= sd;
		do @(posedge clk); while (!req_if.ready);
	endtask

	task automatic wait_drained();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (2) @(posedge clk);
	endtask

	// sda_sel: 0 or 1 holds the line level, 2 randomizes it every tick
	task automatic run_cmd(input logic [ActionW-1:0] act, input logic [ByteW-1:0] wb,
			input logic sa, input int sda_sel);
		send_req(act, wb, sa, (sda_sel == 2) ? 1'($urandom) : 1'(sda_sel));
		do begin
			send_req(ACT_TICK, ByteW'($urandom), 1'($urandom),
				(sda_sel == 2) ? 1'($urandom) : 1'(sda_sel));
		end while (engine_busy);
	endtask

	task automatic set_half_period(input logic [HalfW-1:0] hp);
		wait_drained();
		while (engine_busy) begin
			send_req(ACT_TICK, '0, 1'b0, 1'b1);
			wait_drained();
		end
		cfg_we <= 1'b1;
		cfg_data <= hp;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_traffic(input int n);
		logic [ActionW-1:0] act;
		for (int i = 0; i < n; i++) begin
			if (!engine_busy && $urandom_range(99, 0) < 60)
				act = ActionW'($urandom_range(ACT_READ, ACT_START));
			else if ($urandom_range(99, 0) < 8)
				act = ActionW'($urandom_range(7, 0));
			else
				act = ACT_TICK;
			send_req(act, ByteW'($urandom), 1'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		cfg_we <= 1'b0;
		cfg_data <= '0;
		req_if.valid <= 1'b0;
		req_if.action <= ACT_TICK;
		req_if.write_byte <= '0;
		req_if.send_ack <= 1'b0;
		req_if.sda_in <= 1'b0;
		sender_gap_pct = 15;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_cmd(3'd5, 8'h00, 1'b0, 0);
		run_cmd(3'd6, 8'hFF, 1'b1, 1);
		run_cmd(3'd7, 8'h00, 1'b0, 0);
		run_cmd(ACT_TICK, 8'hFF, 1'b1, 1);
		run_cmd(ACT_START, 8'h00, 1'b0, 1);

		set_half_period(16'd1);
		run_cmd(ACT_START, 8'h00, 1'b0, 1);
		run_cmd(ACT_WRITE, 8'hFF, 1'b0, 0);
		run_cmd(ACT_WRITE, 8'h00, 1'b1, 1);
		run_cmd(ACT_READ, 8'h00, 1'b1, 1);
		run_cmd(ACT_READ, 8'hFF, 1'b0, 0);
		send_req(ACT_WRITE, 8'h5A, 1'b0, 1'b1);
		run_cmd(ACT_READ, 8'hA5, 1'b1, 2);
		run_cmd(ACT_STOP, 8'h00, 1'b0, 1);

		set_half_period(16'd0);
		run_cmd(ACT_START, 8'h00, 1'b0, 1);
		run_cmd(ACT_WRITE, 8'hA5, 1'b0, 2);
		run_cmd(ACT_READ, 8'h3C, 1'b1, 2);
		run_cmd(ACT_STOP, 8'h00, 1'b0, 1);

		set_half_period(16'd1);
		random_traffic(100);
		hold_token <= hold_token + 1;
		random_traffic(100);
		wait_drained();
		random_traffic(100);

		set_half_period(16'd2);
		sender_gap_pct = 0;
		random_traffic(300);
		sender_gap_pct = 15;

		set_half_period(16'd3);
		random_traffic(300);
		set_half_period(HalfW'($urandom_range(9, 5)));
		random_traffic(300);
		set_half_period(16'd0);
		random_traffic(300);
		set_half_period(HalfPeriodReset);
		random_traffic(300);

		set_half_period(16'hFFFF);
		send_req(ACT_START, 8'h00, 1'b0, 1'b1);
		repeat (20) send_req(ACT_TICK, 8'h00, 1'b0, 1'b1);

		// shorten the period in the middle of a long phase
		wait_drained();
		cfg_we <= 1'b1;
		cfg_data <= 16'd1;
		@(posedge clk);
		cfg_we <= 1'b0;
		random_traffic(50);

		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("i2c_master_byte_engine_unit verification clean");
		else
			$display("i2c_master_byte_engine_unit verification failed");
		$finish;
	end

endmodule
